// ----- sv/kda_pkg.sv -----
// ---------------------------------------------------------------------------
// kda_pkg
// Shared types, constants and helpers for the keypad debounce/auto-repeat block.
// ---------------------------------------------------------------------------
`default_nettype none

package kda_pkg;

  localparam int ROWS       = 8;
  localparam int COLS       = 8;
  localparam int ROW_STRIDE = 8;
  localparam int MAP_W      = 64;
  localparam int CODE_W     = 6;
  localparam int TIME_W     = 32;
  localparam int CFG_W      = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int OUT_CODE_W = 8;
  localparam int FIFO_DEPTH = 2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd10;
  localparam logic [CFG_W-1:0] HOLD_RST     = 16'd500;
  localparam logic [CFG_W-1:0] REPEAT_RST   = 16'd100;
  localparam logic [OUT_CODE_W-1:0] KEY_NONE = 8'hff;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_HOLD     = 2'd1,
    REG_REPEAT   = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_PUSHED   = 2'd2,
    PH_HOLD     = 2'd3
  } phase_t;

  // classified scan handed from front to back
  typedef struct packed {
    logic              found;
    logic [CODE_W-1:0] code;
    logic [TIME_W-1:0] now_ms;
  } scan_t;

  // keys that exist in the matrix
  function automatic logic [MAP_W-1:0] key_mask();
    logic [MAP_W-1:0] m;
    m = '0;
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 8; c++) begin
        if (r < ROWS && c < COLS) begin
          m[r*ROW_STRIDE+c] = 1'b1;
        end
      end
    end
    return m;
  endfunction

  localparam logic [MAP_W-1:0] KEY_MASK = key_mask();

endpackage

`default_nettype wire

// ----- sv/kda_front.sv -----
// ---------------------------------------------------------------------------
// kda_front
// Accepts scans, finds the lowest pressed in-matrix key, holds it for the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module kda_front import kda_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [MAP_W-1:0]  key_map,
  input  wire logic [TIME_W-1:0] now_ms,
  output logic                   push,
  output scan_t                  push_entry,
  input  wire logic              full
);

  logic              stage_valid;
  scan_t             stage;
  logic [MAP_W-1:0]  masked;
  logic              found;
  logic [CODE_W-1:0] code;

  assign masked = key_map & KEY_MASK;

  // priority encoder, lowest index wins
  always_comb begin
    code = '0;
    for (int i = MAP_W - 1; i >= 0; i--) begin
      if (masked[i]) begin
        code = CODE_W'(i);
      end
    end
    found = |masked;
  end

  assign push       = stage_valid && !full;
  assign in_ready   = !stage_valid || !full;
  assign push_entry = stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_valid <= 1'b1;
    end else if (push) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage.found  <= found;
      stage.code   <= code;
      stage.now_ms <= now_ms;
    end
  end

endmodule

`default_nettype wire

// ----- sv/kda_fifo.sv -----
// ---------------------------------------------------------------------------
// kda_fifo
// Short queue of classified scans between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module kda_fifo import kda_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire scan_t push_entry,
  input  wire logic  pop,
  output scan_t      head,
  output logic       not_empty,
  output logic       full
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(FIFO_DEPTH - 1);

  scan_t            entries [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign not_empty = (count != '0);
  assign full      = (count == CNT_W'(FIFO_DEPTH));
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// ----- sv/kda_back.sv -----
// ---------------------------------------------------------------------------
// kda_back
// Phase machine: debounce, first report, hold delay and auto-repeat.
// ---------------------------------------------------------------------------
`default_nettype none

module kda_back import kda_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]      cfg_data,
  input  wire scan_t                 head,
  input  wire logic                  head_valid,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       key_event,
  output logic [OUT_CODE_W-1:0]      key_code
);

  logic [CFG_W-1:0]  debounce_ms;
  logic [CFG_W-1:0]  hold_delay_ms;
  logic [CFG_W-1:0]  repeat_ms;

  phase_t            phase;
  phase_t            phase_next;
  logic [CODE_W-1:0] tracked_key;
  logic [TIME_W-1:0] time_mark;

  logic [CFG_W-1:0]  limit;
  logic [TIME_W-1:0] elapsed;
  logic              due;
  logic              same_key;
  logic              report;
  logic              latch_key;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms   <= DEBOUNCE_RST;
      hold_delay_ms <= HOLD_RST;
      repeat_ms     <= REPEAT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_DEBOUNCE: debounce_ms   <= cfg_data;
        REG_HOLD:     hold_delay_ms <= cfg_data;
        REG_REPEAT:   repeat_ms     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign pop = head_valid && (!out_valid || out_ready);

  always_comb begin
    case (phase)
      PH_DEBOUNCE: limit = debounce_ms;
      PH_PUSHED:   limit = hold_delay_ms;
      default:     limit = repeat_ms;
    endcase
  end

  // wrapping difference
  assign elapsed  = head.now_ms - time_mark;
  assign due      = elapsed >= {{(TIME_W-CFG_W){1'b0}}, limit};
  assign same_key = (head.code == tracked_key);

  always_comb begin
    phase_next = phase;
    if (!head.found) begin
      phase_next = PH_IDLE;
    end else if (phase == PH_IDLE) begin
      phase_next = PH_DEBOUNCE;
    end else if (!same_key) begin
      phase_next = PH_IDLE;
    end else if (due) begin
      phase_next = (phase == PH_DEBOUNCE) ? PH_PUSHED : PH_HOLD;
    end
  end

  always_comb begin
    latch_key = head.found && (phase == PH_IDLE);
    report    = head.found && (phase != PH_IDLE) && same_key && due;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      tracked_key <= '0;
      time_mark   <= '0;
    end else if (pop) begin
      phase <= phase_next;
      if (latch_key) begin
        tracked_key <= head.code;
      end
      if (latch_key || report) begin
        time_mark <= head.now_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      key_event <= report;
      key_code  <= report ? {{(OUT_CODE_W-CODE_W){1'b0}}, tracked_key} : KEY_NONE;
    end
  end

endmodule

`default_nettype wire

// ----- sv/keypad_debounce_autorepeat.sv -----
// ---------------------------------------------------------------------------
// keypad_debounce_autorepeat
// Debounce and auto-repeat for an 8x8 key matrix scan stream.
// ---------------------------------------------------------------------------
// Takes one matrix scan per cycle while s_tready is high and returns exactly one
// result per scan, in order. A scan passes a front register (lowest pressed key
// found by a priority encoder), a two-entry queue and the phase machine's
// output register, from which its result is offered on m_tvalid; with m_tready
// held high the block sustains one scan per cycle. With the output stalled the
// block holds four scans in all, output register included, before s_tready
// drops. Timing registers are written through the cfg port; the user must write
// them only while the stream is idle, as the block itself does not enforce it.
`default_nettype none

module keypad_debounce_autorepeat import kda_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]      cfg_data,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [95:0]           s_tdata,   // key_map[63:0], now_ms[95:64]
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [7:0]                 m_tdata,   // key_code[7:0]
  output logic                       m_tuser    // key_event[0]
);

  logic  push;
  scan_t push_entry;
  logic  full;
  logic  pop;
  scan_t head;
  logic  not_empty;

  kda_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .key_map    (s_tdata[MAP_W-1:0]),
    .now_ms     (s_tdata[MAP_W+TIME_W-1:MAP_W]),
    .push       (push),
    .push_entry (push_entry),
    .full       (full)
  );

  kda_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .not_empty  (not_empty),
    .full       (full)
  );

  kda_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .head       (head),
    .head_valid (not_empty),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .key_event  (m_tuser),
    .key_code   (m_tdata)
  );

endmodule

`default_nettype wire

// ----- sv/kda_checker.sv -----
// ---------------------------------------------------------------------------
// kda_checker
// Port-level checks for the keypad debounce/auto-repeat block.
// ---------------------------------------------------------------------------
`default_nettype none

module kda_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [7:0]  m_tdata,
  input wire logic        m_tuser
);

  // reported key lies inside the matrix
  a_event_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[7:6] == 2'b00)
    else $error("key event with code out of range");

  // no event means the no-key code
  a_idle_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 8'hff)
    else $error("non-event request carries a key code");

  // reset empties the output side
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result present right after reset");

  // stalled request holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output request changed while stalled");

  // input only backs up behind a pending result
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no result pending");

endmodule

bind keypad_debounce_autorepeat kda_checker u_kda_checker (.*);

`default_nettype wire

// ----- verif/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench
// Stream-level check of keypad_debounce_autorepeat: scans go in through a
// queue-fed driver and results are matched in order against a phase-machine
// predictor, across several timing register settings and idle patterns.
// ---------------------------------------------------------------------------
module testbench;
  import kda_pkg::*;

  typedef struct {
    logic [MAP_W-1:0]  key_map;
    logic [TIME_W-1:0] now_ms;
  } scan_item_t;

  typedef struct packed {
    logic                  key_event;
    logic [OUT_CODE_W-1:0] key_code;
  } key_report_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SEG_ITEMS      = 200;
  localparam int STALL_CYCLES   = 200;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = REG_DEBOUNCE;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [95:0]           s_tdata = '0;   // key_map[63:0], now_ms[95:64]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [7:0]            m_tdata;        // key_code[7:0]
  logic                  m_tuser;        // key_event[0]

  keypad_debounce_autorepeat dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the registers and the phase machine
  logic [CFG_W-1:0]  debounce_ms = DEBOUNCE_RST;
  logic [CFG_W-1:0]  hold_ms     = HOLD_RST;
  logic [CFG_W-1:0]  repeat_ms   = REPEAT_RST;
  phase_t            pred_phase  = PH_IDLE;
  logic [CODE_W-1:0] pred_key    = '0;
  logic [TIME_W-1:0] pred_mark   = '0;

  scan_item_t  scan_q[$];
  key_report_t report_q[$];
  scan_item_t  cur_scan;
  logic [TIME_W-1:0] t_now;

  int send_idle_pct = 7;
  int recv_idle_pct = 73;
  int n_scans   = 0;
  int n_results = 0;
  int n_events  = 0;
  int n_cfg     = 0;
  int n_err     = 0;
  int idle_cycles = 0;
  int stall_left  = 0;
  bit stall_done  = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    n_err++;
  endtask

  function automatic void predict_report(input logic [MAP_W-1:0] map,
                                         input logic [TIME_W-1:0] now);
    logic              found;
    logic [CODE_W-1:0] code;
    logic [TIME_W-1:0] limit;
    key_report_t       rep;
    found = 1'b0;
    code  = '0;
    limit = '0;
    rep.key_event = 1'b0;
    rep.key_code  = KEY_NONE;
    // scan downward so the last hit is the lowest index
    for (int r = ROWS - 1; r >= 0; r--) begin
      for (int c = COLS - 1; c >= 0; c--) begin
        if (map[r*ROW_STRIDE+c]) begin
          found = 1'b1;
          code  = CODE_W'(r*ROW_STRIDE + c);
        end
      end
    end
    if (!found) begin
      pred_phase = PH_IDLE;
    end else if (pred_phase == PH_IDLE) begin
      pred_phase = PH_DEBOUNCE;
      pred_key   = code;
      pred_mark  = now;
    end else if (code != pred_key) begin
      pred_phase = PH_IDLE;
    end else begin
      case (pred_phase)
        PH_DEBOUNCE: limit = TIME_W'(debounce_ms);
        PH_PUSHED:   limit = TIME_W'(hold_ms);
        default:     limit = TIME_W'(repeat_ms);
      endcase
      if (TIME_W'(now - pred_mark) >= limit) begin
        rep.key_event = 1'b1;
        rep.key_code  = OUT_CODE_W'(pred_key);
        pred_phase    = (pred_phase == PH_DEBOUNCE) ? PH_PUSHED : PH_HOLD;
        pred_mark     = now;
      end
    end
    report_q.push_back(rep);
  endfunction

  function automatic void push_scan(input logic [MAP_W-1:0] map,
                                    input logic [TIME_W-1:0] now);
    scan_item_t it;
    it.key_map = map;
    it.now_ms  = now;
    scan_q.push_back(it);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_report(cur_scan.key_map, cur_scan.now_ms);
        n_scans++;
      end
      if (!s_tvalid || s_tready) begin
        if (scan_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_scan = scan_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {cur_scan.now_ms, cur_scan.key_map};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with one long hold-off so the input side backs up
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if (!stall_done && n_results >= 300) begin
      stall_done = 1'b1;
      stall_left = STALL_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    key_report_t exp_rep;
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (m_tuser) n_events++;
      if (report_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result event=%0b code=%0d", m_tuser, m_tdata));
      end else begin
        exp_rep = report_q.pop_front();
        if (m_tuser !== exp_rep.key_event)
          report_mismatch($sformatf("result %0d key_event got %0b want %0b",
                                    n_results, m_tuser, exp_rep.key_event));
        if (m_tdata !== exp_rep.key_code)
          report_mismatch($sformatf("result %0d key_code got %0d want %0d",
                                    n_results, m_tdata, exp_rep.key_code));
      end
    end
  end

  // watchdog on cycles with no request moving on either side
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", idle_cycles);
        $display("keypad_debounce_autorepeat test failed");
        $finish;
      end
    end
  end

  // sampled at the falling edge so nothing is mid-update
  task automatic wait_drained();
    do @(negedge clk);
    while (scan_q.size() != 0 || s_tvalid || report_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    case (idx)
      REG_DEBOUNCE: debounce_ms = val;
      REG_HOLD:     hold_ms     = val;
      default:      repeat_ms   = val;
    endcase
  endtask

  task automatic gen_scans(input int n, input int step_max);
    int made;
    int k;
    int len;
    int pick;
    logic [MAP_W-1:0] map;
    logic [MAP_W-1:0] one;
    one  = 64'd1;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        // one key held down, higher keys may chatter alongside
        k   = $urandom_range(0, 63);
        len = $urandom_range(2, 25);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 19) == 0) begin
            map = {$urandom, $urandom};
          end else begin
            map = {$urandom, $urandom} & ~((one << (k + 1)) - one);
            if ($urandom_range(0, 1)) map = '0;
            map = map | (one << k);
          end
          t_now += $urandom_range(0, step_max);
          push_scan(map, t_now);
          made++;
        end
      end else if (pick < 85) begin
        t_now += $urandom_range(0, step_max);
        push_scan({$urandom, $urandom}, t_now);
        made++;
      end else if (pick < 93) begin
        t_now += $urandom_range(0, step_max);
        push_scan('0, t_now);
        made++;
      end else begin
        // jump anywhere on the clock, including backward
        t_now = $urandom;
        push_scan(one << $urandom_range(0, 63), t_now);
        made++;
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] d;
    logic [CFG_W-1:0] h;
    logic [CFG_W-1:0] r;
    int mx;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed part at reset timing: 10 / 500 / 100
    push_scan('0, 32'd0);
    push_scan(64'h8000_0000_0000_0000, 32'd100);
    push_scan(64'h8000_0000_0000_0000, 32'd105);
    push_scan(64'h8000_0000_0000_0000, 32'd110);
    push_scan(64'h8000_0000_0000_0000, 32'd400);
    push_scan(64'h8000_0000_0000_0000, 32'd610);
    push_scan(64'h8000_0000_0000_0000, 32'd700);
    push_scan(64'h8000_0000_0000_0000, 32'd710);
    push_scan(64'h8000_0000_0000_0000, 32'd810);
    // different key while held
    push_scan('1, 32'd820);
    push_scan('1, 32'd830);
    // different key while debouncing
    push_scan(64'h0000_0000_0000_0020, 32'd840);
    push_scan('0, 32'd850);
    // wrap of the millisecond counter
    push_scan(64'h0000_0000_0000_0001, 32'hffff_fff8);
    push_scan(64'h0000_0000_0000_0001, 32'hffff_fffe);
    push_scan(64'h0000_0000_0000_0001, 32'd2);
    push_scan(64'h0000_0000_0000_0001, 32'd0);
    push_scan(64'h0000_0000_0000_0001, 32'hffff_ffff);
    push_scan(64'h0000_0000_0000_0001, 32'h0000_0063);
    push_scan('0, 32'h0000_0064);
    t_now = 32'h0000_1000;

    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        0: begin d = 16'd0;     h = 16'd0;     r = 16'd0;     end
        1: begin d = 16'd3;     h = 16'd20;    r = 16'd5;     end
        2: begin d = 16'hffff;  h = 16'hffff;  r = 16'hffff;  end
        3: begin d = 16'd1;     h = 16'hffff;  r = 16'd0;     end
        4: begin d = 16'd25;    h = 16'd40;    r = 16'd7;     end
        default: begin
          d = CFG_W'($urandom_range(0, 60));
          h = CFG_W'($urandom_range(0, 60));
          r = CFG_W'($urandom_range(0, 60));
        end
      endcase
      wait_drained();
      write_reg(REG_DEBOUNCE, d);
      write_reg(REG_HOLD, h);
      write_reg(REG_REPEAT, r);
      @(posedge clk);
      cfg_we <= 1'b0;
      n_cfg++;
      // sender mostly busy, then receiver mostly busy, then no idling
      if (seg < 2) begin
        send_idle_pct = 7;
        recv_idle_pct = 73;
      end else if (seg < 4) begin
        send_idle_pct = 73;
        recv_idle_pct = 7;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      mx = int'(d);
      if (int'(h) > mx) mx = int'(h);
      if (int'(r) > mx) mx = int'(r);
      gen_scans(SEG_ITEMS, mx / 3 + 3);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (report_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", report_q.size()));
    $display("ran %0d scans over %0d timing settings, %0d key reports seen",
             n_scans, n_cfg + 1, n_events);
    $display("%0d results checked, %0d mismatches", n_results, n_err);
    if (n_err == 0) begin
      $display("keypad_debounce_autorepeat test passed");
    end else begin
      $display("keypad_debounce_autorepeat test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/kda_pkg.sv
sv/kda_front.sv
sv/kda_fifo.sv
sv/kda_back.sv
sv/keypad_debounce_autorepeat.sv
sv/kda_checker.sv
verif/testbench.sv
